@@ rtl/nood_pkg.sv @@
package nood_pkg;

    // sample and peak widths follow the Q1.15 payload format
    localparam int SAMPLE_BITS = 16;
    localparam int PEAK_W      = SAMPLE_BITS - 1;
    localparam int INDEX_W     = 32;
    localparam int MDUR_W      = 8;
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_INDEX_W = 1;

    localparam int DEF_WINDOW_CHUNKS = 3;

    // silent when SILENT_RATIO * peak < max, rise when dyn << RISE_SHIFT > max
    localparam int SILENT_RATIO  = 25;
    localparam int SILENT_PROD_W = PEAK_W + 5;
    localparam int RISE_SHIFT    = 2;

    localparam logic [MDUR_W-1:0] MIN_DURATION_RST = MDUR_W'(3);
    localparam logic [PEAK_W-1:0] PEAK_FLOOR_RST   = PEAK_W'(6554);

    // command codes
    localparam logic [1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_SKIP    = 2'd1;
    localparam logic [1:0] CMD_ACCEPT  = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DURATION = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_FLOOR   = 1'd1;

    typedef struct packed {
        logic [1:0]                    cmd;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          chunk_last;
    } in_item_t;

    typedef struct packed {
        logic                      note_started;
        logic                      note_finished;
        logic                      rest_started;
        logic                      rest_finished;
        logic signed [INDEX_W-1:0] started_at;
        logic signed [INDEX_W-1:0] finished_at;
        logic [PEAK_W-1:0]         chunk_peak;
    } out_item_t;

    // request handed from the sample tracker to the chunk evaluator
    typedef struct packed {
        logic [1:0]        cmd;
        logic [PEAK_W-1:0] peak;
    } mid_item_t;

endpackage

@@ rtl/nood_tracker.sv @@
module nood_tracker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_vld,
    input  nood_pkg::in_item_t  item,
    output logic                take,
    output logic                mid_vld,
    output nood_pkg::mid_item_t mid_item,
    input  logic                mid_take
);

    logic signed [nood_pkg::SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic                                    first_reg, first_next;
    logic                                    inpos_reg, inpos_next;
    logic [nood_pkg::PEAK_W-1:0]             hcp_reg, hcp_next;
    logic [nood_pkg::PEAK_W-1:0]             acc_reg, acc_next;
    logic                                    mid_vld_reg, mid_vld_next;
    nood_pkg::mid_item_t                     mid_item_reg, mid_item_next;
    logic                                    fwd;
    logic signed [nood_pkg::SAMPLE_BITS-1:0] s;

    assign take     = item_vld && (!mid_vld_reg || mid_take);
    assign mid_vld  = mid_vld_reg;
    assign mid_item = mid_item_reg;
    assign s        = item.sample;

    always_comb
    begin
        prev_next          = prev_reg;
        first_next         = first_reg;
        inpos_next         = inpos_reg;
        hcp_next           = hcp_reg;
        acc_next           = acc_reg;
        fwd                = 1'b0;
        mid_item_next.cmd  = item.cmd;
        mid_item_next.peak = acc_reg;
        case (item.cmd)
            nood_pkg::CMD_SAMPLE:
            begin
                if (first_reg)
                begin
                    first_next = 1'b0;
                end
                else
                begin
                    if (prev_reg <= 0 && s >= 0)
                    begin
                        inpos_next = 1'b1;
                    end
                    else if (prev_reg >= 0 && s <= 0)
                    begin
                        // falling crossing closes the half-cycle
                        if (hcp_reg > acc_reg)
                        begin
                            acc_next = hcp_reg;
                        end
                        inpos_next = 1'b0;
                        hcp_next   = '0;
                    end
                    if (inpos_next && s > 0 && s[nood_pkg::PEAK_W-1:0] > hcp_next)
                    begin
                        hcp_next = s[nood_pkg::PEAK_W-1:0];
                    end
                end
                prev_next          = s;
                mid_item_next.peak = acc_next;
                if (item.chunk_last)
                begin
                    fwd        = 1'b1;
                    first_next = 1'b1;
                    inpos_next = 1'b0;
                    hcp_next   = '0;
                    acc_next   = '0;
                end
            end
            nood_pkg::CMD_RESTART:
            begin
                fwd        = 1'b1;
                first_next = 1'b1;
                inpos_next = 1'b0;
                hcp_next   = '0;
                acc_next   = '0;
            end
            default:
            begin
                fwd = 1'b1;
            end
        endcase

        if (take)
        begin
            mid_vld_next = fwd;
        end
        else if (mid_take)
        begin
            mid_vld_next = 1'b0;
        end
        else
        begin
            mid_vld_next = mid_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            first_reg   <= 1'b1;
            inpos_reg   <= 1'b0;
            hcp_reg     <= '0;
            acc_reg     <= '0;
            mid_vld_reg <= 1'b0;
        end
        else
        begin
            mid_vld_reg <= mid_vld_next;
            if (take)
            begin
                prev_reg  <= prev_next;
                first_reg <= first_next;
                inpos_reg <= inpos_next;
                hcp_reg   <= hcp_next;
                acc_reg   <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mid_item_reg <= mid_item_next;
        end
    end

endmodule

@@ rtl/nood_evaluator.sv @@
module nood_evaluator #(
    parameter int WINDOW_CHUNKS = nood_pkg::DEF_WINDOW_CHUNKS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [nood_pkg::MDUR_W-1:0]         min_duration,
    input  logic [nood_pkg::PEAK_W-1:0]         peak_floor,
    input  logic                                mid_vld,
    input  nood_pkg::mid_item_t                 mid_item,
    output logic                                mid_take,
    output logic                                out_vld,
    output nood_pkg::out_item_t                 out_item,
    input  logic                                out_rdy
);

    localparam int FILL_W = $clog2(WINDOW_CHUNKS + 1);
    localparam int POS_W  = $clog2(WINDOW_CHUNKS);
    localparam int IW     = nood_pkg::INDEX_W;
    localparam int PW     = nood_pkg::PEAK_W;
    localparam int SPW    = nood_pkg::SILENT_PROD_W;

    typedef enum logic [1:0] {
        PH_INITIAL,
        PH_ONSET,
        PH_PENDING,
        PH_SILENCE
    } phase_t;

    logic [PW-1:0]       win_reg [WINDOW_CHUNKS];
    logic [PW-1:0]       win_next [WINDOW_CHUNKS];
    logic [PW-1:0]       win_upd [WINDOW_CHUNKS];
    logic [FILL_W-1:0]   fill_reg, fill_next, fill_upd;
    logic [PW-1:0]       rmax_reg, rmax_next, rmax_upd;
    logic [IW-1:0]       idx_reg, idx_next, idx_upd;
    logic [IW-1:0]       nstart_reg, nstart_next;
    logic [IW-1:0]       nend_reg, nend_next;
    logic [IW-1:0]       sstart_reg, sstart_next;
    phase_t              phase_reg, phase_next;
    logic                nopen_reg, nopen_next;
    logic                ropen_reg, ropen_next;
    logic                accepted_reg, accepted_next;
    logic                out_vld_reg, out_vld_next;
    nood_pkg::out_item_t out_item_reg, out_item_next;

    logic [PW-1:0]       peak;
    logic [PW-1:0]       hi;
    logic [PW:0]         lo;
    logic [POS_W-1:0]    hi_at, lo_at;
    logic                hi_found;
    logic [PW-1:0]       dyn;
    logic                silent, rise, late, due_old;
    logic [IW-1:0]       d_start, d_silence, d_new_start, d_new_silence, md_ext;
    logic                note_start_due, rest_start_due, nf, rf;

    assign peak     = mid_item.peak;
    assign mid_take = mid_vld && (mid_item.cmd != nood_pkg::CMD_SAMPLE ||
                                  !out_vld_reg || out_rdy);
    assign out_vld  = out_vld_reg;
    assign out_item = out_item_reg;
    assign md_ext   = IW'(min_duration);

    // window slide, running max and min/max scan of the updated window
    always_comb
    begin
        win_upd  = win_reg;
        fill_upd = fill_reg;
        if (fill_reg == FILL_W'(WINDOW_CHUNKS))
        begin
            for (int c = 1; c < WINDOW_CHUNKS; c++)
            begin
                win_upd[c-1] = win_reg[c];
            end
            win_upd[WINDOW_CHUNKS-1] = peak;
        end
        else
        begin
            for (int c = 0; c < WINDOW_CHUNKS; c++)
            begin
                if (FILL_W'(c) == fill_reg)
                begin
                    win_upd[c] = peak;
                end
            end
            fill_upd = fill_reg + FILL_W'(1);
        end
        rmax_upd = (peak > rmax_reg) ? peak : rmax_reg;
        idx_upd  = idx_reg + IW'(1);

        hi       = '0;
        lo       = {1'b1, {PW{1'b0}}};
        hi_at    = '0;
        lo_at    = '0;
        hi_found = 1'b0;
        for (int c = 0; c < WINDOW_CHUNKS; c++)
        begin
            if (FILL_W'(c) < fill_upd)
            begin
                if (win_upd[c] > hi)
                begin
                    hi       = win_upd[c];
                    hi_at    = POS_W'(c);
                    hi_found = 1'b1;
                end
                if ({1'b0, win_upd[c]} < lo)
                begin
                    lo    = {1'b0, win_upd[c]};
                    lo_at = POS_W'(c);
                end
            end
        end
        // an all-zero window never sets hi_found, so it gives no rise
        dyn = (hi_found && hi_at > lo_at) ? (hi - lo[PW-1:0]) : '0;

        silent    = (SPW'(peak) * SPW'(nood_pkg::SILENT_RATIO)) < SPW'(rmax_upd);
        rise      = ({dyn, {nood_pkg::RISE_SHIFT{1'b0}}}) >
                    (PW + nood_pkg::RISE_SHIFT)'(rmax_upd);
        d_start   = idx_upd - nstart_reg;
        late      = !d_start[IW-1] && (d_start > md_ext);
        d_silence = idx_upd - sstart_reg;
        due_old   = d_silence == md_ext;
    end

    // volume phase machine and command handling
    always_comb
    begin
        win_next      = win_reg;
        fill_next     = fill_reg;
        rmax_next     = rmax_reg;
        idx_next      = idx_reg;
        nstart_next   = nstart_reg;
        nend_next     = nend_reg;
        sstart_next   = sstart_reg;
        phase_next    = phase_reg;
        nopen_next    = nopen_reg;
        ropen_next    = ropen_reg;
        accepted_next = accepted_reg;
        out_vld_next  = out_vld_reg && !out_rdy;
        out_item_next = out_item_reg;
        nf            = 1'b0;
        rf            = 1'b0;
        d_new_start   = '0;
        d_new_silence = '0;
        note_start_due = 1'b0;
        rest_start_due = 1'b0;

        if (mid_take)
        begin
            case (mid_item.cmd)
                nood_pkg::CMD_SKIP:
                begin
                    nopen_next = 1'b0;
                end
                nood_pkg::CMD_ACCEPT:
                begin
                    accepted_next = 1'b1;
                end
                nood_pkg::CMD_RESTART:
                begin
                    for (int c = 0; c < WINDOW_CHUNKS; c++)
                    begin
                        win_next[c] = '0;
                    end
                    fill_next     = '0;
                    rmax_next     = peak_floor;
                    idx_next      = '1;
                    nstart_next   = '0;
                    nend_next     = '0;
                    phase_next    = PH_INITIAL;
                    nopen_next    = 1'b0;
                    ropen_next    = 1'b0;
                    accepted_next = 1'b0;
                end
                default:
                begin
                    win_next  = win_upd;
                    fill_next = fill_upd;
                    rmax_next = rmax_upd;
                    idx_next  = idx_upd;
                    if (silent)
                    begin
                        case (phase_reg)
                            PH_PENDING:
                            begin
                                phase_next  = PH_SILENCE;
                                sstart_next = idx_upd;
                            end
                            PH_SILENCE:
                            begin
                                if (due_old && nopen_reg)
                                begin
                                    nend_next  = sstart_reg - IW'(1);
                                    nf         = 1'b1;
                                    nopen_next = 1'b0;
                                end
                            end
                            PH_ONSET:
                            begin
                                nstart_next = '0;
                                phase_next  = PH_SILENCE;
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                    else if (phase_reg != PH_ONSET && rise && late)
                    begin
                        // new onset: the note starts at the window low
                        if (nopen_reg)
                        begin
                            nend_next  = idx_upd - (IW'(WINDOW_CHUNKS) - IW'(lo_at));
                            nf         = 1'b1;
                            nopen_next = 1'b0;
                        end
                        if (ropen_reg)
                        begin
                            ropen_next = 1'b0;
                            rf         = 1'b1;
                        end
                        nstart_next = idx_upd - (IW'(WINDOW_CHUNKS - 1) - IW'(lo_at));
                        phase_next  = PH_ONSET;
                    end
                    else if (phase_reg == PH_ONSET)
                    begin
                        phase_next = PH_PENDING;
                    end
                    else if (phase_reg == PH_SILENCE)
                    begin
                        if (due_old && nopen_reg)
                        begin
                            nend_next  = sstart_reg - IW'(1);
                            nf         = 1'b1;
                            nopen_next = 1'b0;
                        end
                    end

                    d_new_start    = idx_upd - nstart_next;
                    d_new_silence  = idx_upd - sstart_next;
                    note_start_due = (phase_next == PH_PENDING) && (d_new_start == md_ext);
                    rest_start_due = accepted_reg && (phase_next == PH_SILENCE) &&
                                     (d_new_silence == md_ext);
                    if (note_start_due)
                    begin
                        nopen_next = 1'b1;
                    end
                    if (rest_start_due)
                    begin
                        ropen_next = 1'b1;
                    end

                    out_vld_next               = 1'b1;
                    out_item_next.note_started  = note_start_due;
                    out_item_next.note_finished = nf;
                    out_item_next.rest_started  = rest_start_due;
                    out_item_next.rest_finished = rf;
                    out_item_next.started_at    = nstart_next;
                    out_item_next.finished_at   = nend_next;
                    out_item_next.chunk_peak    = peak;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < WINDOW_CHUNKS; c++)
            begin
                win_reg[c] <= '0;
            end
            fill_reg     <= '0;
            rmax_reg     <= nood_pkg::PEAK_FLOOR_RST;
            idx_reg      <= '1;
            nstart_reg   <= '0;
            nend_reg     <= '0;
            sstart_reg   <= '0;
            phase_reg    <= PH_INITIAL;
            nopen_reg    <= 1'b0;
            ropen_reg    <= 1'b0;
            accepted_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            out_item_reg <= '0;
        end
        else
        begin
            win_reg      <= win_next;
            fill_reg     <= fill_next;
            rmax_reg     <= rmax_next;
            idx_reg      <= idx_next;
            nstart_reg   <= nstart_next;
            nend_reg     <= nend_next;
            sstart_reg   <= sstart_next;
            phase_reg    <= phase_next;
            nopen_reg    <= nopen_next;
            ropen_reg    <= ropen_next;
            accepted_reg <= accepted_next;
            out_vld_reg  <= out_vld_next;
            out_item_reg <= out_item_next;
        end
    end

endmodule

@@ rtl/note_onset_offset_detector.sv @@
// a chunk-ending sample reaches out_valid via the input, tracker and result registers
// throughput: one request per cycle; only the output register backpressures the pipe
// stages: input register, sample tracker (zero crossings, half-cycle peak), chunk evaluator
// reset (rst_n, async, active low): chunk and phase state cleared, running max 6554,
// chunk index -1, min_duration 3; no memory clearing pass is needed
module note_onset_offset_detector #(
    parameter int WINDOW_CHUNKS = nood_pkg::DEF_WINDOW_CHUNKS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [nood_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nood_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input requests
    input  logic                             in_valid,
    output logic                             in_ready,
    input  nood_pkg::in_item_t               in_item,
    // result requests
    output logic                             out_valid,
    input  logic                             out_ready,
    output nood_pkg::out_item_t              out_item
);

    logic [nood_pkg::MDUR_W-1:0] min_dur_reg;
    logic [nood_pkg::PEAK_W-1:0] floor_reg;
    logic                        in_vld_reg, in_vld_next;
    nood_pkg::in_item_t          in_item_reg;
    logic                        trk_take;
    logic                        mid_vld;
    nood_pkg::mid_item_t         mid_item;
    logic                        mid_take;

    // configuration registers; the peak floor only matters at restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dur_reg <= nood_pkg::MIN_DURATION_RST;
            floor_reg   <= nood_pkg::PEAK_FLOOR_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                nood_pkg::REG_MIN_DURATION:
                begin
                    min_dur_reg <= cfg_data[nood_pkg::MDUR_W-1:0];
                end
                nood_pkg::REG_PEAK_FLOOR:
                begin
                    floor_reg <= cfg_data[nood_pkg::PEAK_W-1:0];
                end
                default:
                begin
                    floor_reg <= floor_reg;
                end
            endcase
        end
    end

    // input register: a new request enters when the register is empty or the held one moves on
    assign in_ready = !in_vld_reg || trk_take;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            in_vld_next = 1'b1;
        end
        else if (trk_take)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_item;
        end
    end

    // per-sample tracking; forwards chunk ends and commands only
    nood_tracker u_tracker (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_vld (in_vld_reg),
        .item     (in_item_reg),
        .take     (trk_take),
        .mid_vld  (mid_vld),
        .mid_item (mid_item),
        .mid_take (mid_take)
    );

    // per-chunk window, running max, volume phases and the result register
    nood_evaluator #(
        .WINDOW_CHUNKS (WINDOW_CHUNKS)
    ) u_evaluator (
        .clk          (clk),
        .rst_n        (rst_n),
        .min_duration (min_dur_reg),
        .peak_floor   (floor_reg),
        .mid_vld      (mid_vld),
        .mid_item     (mid_item),
        .mid_take     (mid_take),
        .out_vld      (out_valid),
        .out_item     (out_item),
        .out_rdy      (out_ready)
    );

endmodule
